### hdl/murmur_hash_64a_macros.svh
// Assertion macros shared by the hash engine modules.
`ifndef MURMUR_HASH_64A_MACROS_SVH
`define MURMUR_HASH_64A_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define MMH_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hash engine assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define MMH_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hash engine assertion failed");

`endif

### hdl/mmh64a_pkg.sv
// Package with constants, types and helper functions of the hash engine.
package mmh64a_pkg;

  localparam logic [63:0] MIX_MUL   = 64'hc6a4a7935bd1e995;
  localparam int          MIX_SHIFT = 47;
  localparam logic [3:0]  FULL_WORD = 4'd8;

  // Request to the shared multiplier: multiply operand by MIX_MUL.
  typedef struct packed {
    logic        start;
    logic [63:0] operand;
  } mmh64a_mul_ctl_t;

  // Status of the shared multiplier; product is valid while done is high.
  typedef struct packed {
    logic        busy;
    logic        done;
    logic [63:0] product;
  } mmh64a_mul_sts_t;

  function automatic logic [63:0] shift_xor(input logic [63:0] x);
    return x ^ (x >> MIX_SHIFT);
  endfunction

  // Keeps the low nb bytes of the word; nb is already clamped to eight.
  function automatic logic [63:0] mask_low_bytes(input logic [63:0] word,
                                                 input logic [3:0]  nb);
    logic [63:0] m;
    m = '0;
    for (int i = 0; i < 8; i++) begin
      if (4'(i) < nb) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return word & m;
  endfunction

endpackage

### hdl/mmh64a_mul.sv
// Shared 64-bit multiplier by the mix constant, one 32x32 partial product per cycle.
`include "murmur_hash_64a_macros.svh"

module mmh64a_mul (
  input  logic                        clk,
  input  logic                        rst,
  input  mmh64a_pkg::mmh64a_mul_ctl_t ctl,
  output mmh64a_pkg::mmh64a_mul_sts_t sts
);

  localparam logic [31:0] M_LO = mmh64a_pkg::MIX_MUL[31:0];
  localparam logic [31:0] M_HI = mmh64a_pkg::MIX_MUL[63:32];

  logic [63:0] a;
  logic [1:0]  step;
  logic        busy;
  logic        done;
  logic [63:0] prod;
  logic [63:0] acc;
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] mul_out;

  // The low 64 bits of a*M need aL*ML plus the two cross terms shifted by 32.
  always_comb begin
    mul_a = (step == 2'd2) ? a[63:32] : a[31:0];
    mul_b = (step == 2'd1) ? M_HI : M_LO;
  end

  assign mul_out = 64'(mul_a) * 64'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 2'd0;
    end else begin
      done <= busy && (step == 2'd3);
      if (ctl.start && !busy) begin
        a    <= ctl.operand;
        busy <= 1'b1;
        step <= 2'd0;
      end else if (busy) begin
        step <= step + 2'd1;
        unique case (step)
          2'd0: begin
            prod <= mul_out;
          end
          2'd1: begin
            acc  <= prod;
            prod <= mul_out;
          end
          2'd2: begin
            acc  <= acc + {prod[31:0], 32'h0};
            prod <= mul_out;
          end
          2'd3: begin
            acc  <= acc + {prod[31:0], 32'h0};
            busy <= 1'b0;
          end
          default: begin
            busy <= 1'b0;
          end
        endcase
      end
    end
  end

  assign sts.busy    = busy;
  assign sts.done    = done;
  assign sts.product = acc;

  `MMH_ASSERT_IMP(a_start_idle, clk, rst, ctl.start, !busy)
  `MMH_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `MMH_ASSERT_NXT(a_start_busy, clk, rst, ctl.start, busy)

endmodule

### hdl/murmur_hash_64a.sv
// Streaming MurmurHash2 64A engine: sequencer around one shared multiplier.
// Each 64-bit multiply runs as 32x32 partial products on the shared multiplier.
// An item multiplies once for the starting value on a key's first word, three times
// for a full word, once for a partial word; a last word adds one multiply to finalize.
// Input ready is low while an item is at work; a result waits in the output register.
// Reset (synchronous) clears the seed to 0, drops any open key and empties the output.
`include "murmur_hash_64a_macros.svh"

module murmur_hash_64a (
  input  logic        clk,
  input  logic        rst,
  input  logic        seed_we,
  input  logic [31:0] seed_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] key_word,
  input  logic [3:0]  valid_bytes,
  input  logic [30:0] total_length,
  input  logic        last_word,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [63:0] hash_value
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LEN,
    ST_MIX,
    ST_K1,
    ST_K2,
    ST_H,
    ST_F,
    ST_OUT
  } state_t;

  state_t                      state;
  logic [31:0]                 seed;
  logic [63:0]                 word;
  logic [3:0]                  nbytes;
  logic                        last_flag;
  logic [63:0]                 h;
  logic                        in_key;
  mmh64a_pkg::mmh64a_mul_ctl_t mul_ctl;
  mmh64a_pkg::mmh64a_mul_sts_t mul_sts;
  logic [63:0]                 h_xk;

  mmh64a_mul u_mul (
    .clk (clk),
    .rst (rst),
    .ctl (mul_ctl),
    .sts (mul_sts)
  );

  assign in_ready = (state == ST_IDLE);
  assign h_xk     = h ^ mul_sts.product;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      seed          <= '0;
      in_key        <= 1'b0;
      out_valid     <= 1'b0;
      mul_ctl.start <= 1'b0;
    end else begin
      if (seed_we) begin
        seed <= seed_data;
      end
      if (out_valid && out_ready && state != ST_OUT) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          mul_ctl.start <= in_valid && !in_key;
          if (in_valid) begin
            word      <= key_word;
            nbytes    <= (valid_bytes > mmh64a_pkg::FULL_WORD) ?
                         mmh64a_pkg::FULL_WORD : valid_bytes;
            last_flag <= last_word;
            if (!in_key) begin
              mul_ctl.operand <= {33'h0, total_length};
              state           <= ST_LEN;
            end else begin
              state <= ST_MIX;
            end
          end
        end
        ST_LEN: begin
          mul_ctl.start <= 1'b0;
          if (mul_sts.done) begin
            h     <= {32'h0, seed} ^ mul_sts.product;
            state <= ST_MIX;
          end
        end
        ST_MIX: begin
          mul_ctl.start <= (nbytes != 4'd0) || last_flag;
          priority if (nbytes == mmh64a_pkg::FULL_WORD) begin
            mul_ctl.operand <= word;
            state           <= ST_K1;
          end else if (nbytes != 4'd0) begin
            mul_ctl.operand <= h ^ mmh64a_pkg::mask_low_bytes(word, nbytes);
            state           <= ST_H;
          end else if (last_flag) begin
            mul_ctl.operand <= mmh64a_pkg::shift_xor(h);
            state           <= ST_F;
          end else begin
            // An empty word inside a key leaves the hash as it is.
            in_key <= 1'b1;
            state  <= ST_IDLE;
          end
        end
        ST_K1: begin
          mul_ctl.start <= mul_sts.done;
          if (mul_sts.done) begin
            mul_ctl.operand <= mmh64a_pkg::shift_xor(mul_sts.product);
            state           <= ST_K2;
          end
        end
        ST_K2: begin
          mul_ctl.start <= mul_sts.done;
          if (mul_sts.done) begin
            mul_ctl.operand <= h_xk;
            state           <= ST_H;
          end
        end
        ST_H: begin
          mul_ctl.start <= mul_sts.done && last_flag;
          if (mul_sts.done) begin
            h <= mul_sts.product;
            if (last_flag) begin
              mul_ctl.operand <= mmh64a_pkg::shift_xor(mul_sts.product);
              state           <= ST_F;
            end else begin
              in_key <= 1'b1;
              state  <= ST_IDLE;
            end
          end
        end
        ST_F: begin
          mul_ctl.start <= 1'b0;
          if (mul_sts.done) begin
            h      <= mmh64a_pkg::shift_xor(mul_sts.product);
            in_key <= 1'b0;
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          mul_ctl.start <= 1'b0;
          // The finished hash moves out once the output register is free.
          if (!out_valid || out_ready) begin
            hash_value <= h;
            out_valid  <= 1'b1;
            state      <= ST_IDLE;
          end
        end
        default: begin
          mul_ctl.start <= 1'b0;
          state         <= ST_IDLE;
        end
      endcase
    end
  end

  `MMH_ASSERT_IMP(a_ready_mul_idle, clk, rst, in_ready, !mul_sts.busy)
  `MMH_ASSERT_IMP(a_done_in_wait, clk, rst, mul_sts.done,
                  state != ST_IDLE && state != ST_MIX && state != ST_OUT)
  `MMH_ASSERT_NXT(a_final_to_out, clk, rst, state == ST_F && mul_sts.done,
                  state == ST_OUT && !in_key)

endmodule
